FILE: hdl/fcte_pkg.sv
// ----------------------------------------------------------------------------
// fcte_pkg: types and constants for the cluster table engine
// Shared command codes, status codes, beat structs and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package fcte_pkg;

  localparam int MAX_CLUSTERS = 4096;
  localparam int ENTRY_W = 28;
  localparam int CNT_W = 13;
  localparam logic [27:0] EOC_MARK = 28'hFFFFFFF;
  localparam logic [27:0] EOC_FIRST = 28'hFFFFFF8;
  localparam logic [27:0] FIRST_CLUSTER = 28'd2;

  typedef enum logic [2:0] {
    MODE_READ = 3'd0,
    MODE_WRITE = 3'd1,
    MODE_ALLOC = 3'd2,
    MODE_FREE = 3'd3,
    MODE_TRUNC = 3'd4,
    MODE_COUNT = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_INVALID = 2'd1,
    ST_READ_ONLY = 2'd2,
    ST_NO_SPACE = 2'd3
  } status_t;

  localparam logic [0:0] REG_CLUSTER_COUNT = 1'b0;
  localparam logic [0:0] REG_READ_ONLY = 1'b1;

  typedef struct packed {
    logic [2:0] mode;
    logic [27:0] cluster;
    logic [27:0] entry_value;
    logic [12:0] keep_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [27:0] result_value;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RD,
    S_RD_WAIT,
    S_EVAL,
    S_DONE
  } state_t;

  // memory port command from sequencer to table
  typedef struct packed {
    logic wr_en;
    logic [27:0] wr_data;
  } mem_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/fcte_table.sv
// ----------------------------------------------------------------------------
// fcte_table: cluster table memory
// Single port store, one optional write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module fcte_table #(
  parameter int DEPTH = fcte_pkg::MAX_CLUSTERS,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic clk,
  input  wire logic [AW-1:0] addr,
  input  wire fcte_pkg::mem_cmd_t cmd,
  output logic [27:0] rd_data
);
  logic [27:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= cmd.wr_data;
    end
    rd_data <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: hdl/fat_cluster_table_engine_unit.sv
// ----------------------------------------------------------------------------
// fat_cluster_table_engine_unit: FAT32 cluster table engine
// Sequencer walking one table port for read, write, allocate, free, truncate
// and free count commands.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in_     | input     | in_valid / in_ready, in_data (in_item_t)
// out_    | output    | out_valid / out_ready, out_data (out_item_t)
// cfg_    | input     | APB write/read, pready tied high
//
// Every table visit goes through the states S_RD (issue the read), S_RD_WAIT
// (registered read data) and S_EVAL (evaluate with an optional write) on the
// single table port. The number of entries visited by an item is up to about
// MAX_CLUSTERS for allocate, chain walks and free count scans, and truncate
// adds up to keep_len visits for the kept part. After reset a clearing pass
// zeroes all MAX_CLUSTERS table entries while in_ready stays low. The result
// sits in an output register; the next item is taken only once it has gone.
`default_nettype none
module fat_cluster_table_engine_unit #(
  parameter int MAX_CLUSTERS = fcte_pkg::MAX_CLUSTERS,
  parameter int AW = $clog2(MAX_CLUSTERS)
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire fcte_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output fcte_pkg::out_item_t out_data,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [2:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam logic [27:0] MAXC = 28'(MAX_CLUSTERS);

  logic [12:0] cluster_count_r;
  logic read_only_r;
  logic hint_valid_r, hint_valid_nxt;
  logic [27:0] free_hint_r, free_hint_nxt;
  logic [27:0] next_free_r, next_free_nxt;

  fcte_pkg::state_t state_r, state_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic [27:0] cur_r, cur_nxt;        // cluster being visited
  logic [27:0] val_r, val_nxt;
  logic [12:0] keep_r, keep_nxt;
  logic [27:0] iter_r, iter_nxt;      // visit counter
  logic [27:0] acc_r, acc_nxt;        // scan count
  logic walking_r, walking_nxt;       // truncate: in free phase
  logic [AW:0] clr_r, clr_nxt;
  logic out_valid_r, out_valid_nxt;
  fcte_pkg::out_item_t out_r, out_nxt;

  fcte_pkg::mem_cmd_t cmd;
  logic [AW-1:0] addr;
  logic [27:0] rd_data;

  // configuration port
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == fcte_pkg::REG_READ_ONLY) begin
      cfg_prdata = {31'd0, read_only_r};
    end else begin
      cfg_prdata = {19'd0, cluster_count_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r <= 13'd4096;
      read_only_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == fcte_pkg::REG_CLUSTER_COUNT) begin
        cluster_count_r <= cfg_pwdata[12:0];
      end else begin
        read_only_r <= cfg_pwdata[0];
      end
    end
  end

  logic [27:0] used;
  assign used = ({15'd0, cluster_count_r} > MAXC) ? MAXC : {15'd0, cluster_count_r};

  function automatic logic valid_c(input logic [27:0] c, input logic [27:0] u);
    logic [27:0] d;
    d = c - fcte_pkg::FIRST_CLUSTER;
    return (c >= fcte_pkg::FIRST_CLUSTER) && (d < u);
  endfunction

  logic cur_ok, rd_eoc, rd_ok;
  assign cur_ok = valid_c(cur_r, used);
  assign rd_eoc = rd_data >= fcte_pkg::EOC_FIRST;
  assign rd_ok = valid_c(rd_data, used);

  fcte_table #(.DEPTH(MAX_CLUSTERS), .AW(AW)) u_table (
    .clk(clk), .addr(addr), .cmd(cmd), .rd_data(rd_data)
  );

  assign in_ready = (state_r == fcte_pkg::S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcte_pkg::S_CLEAR;
      clr_r <= '0;
      hint_valid_r <= 1'b0;
      free_hint_r <= '0;
      next_free_r <= fcte_pkg::FIRST_CLUSTER;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      hint_valid_r <= hint_valid_nxt;
      free_hint_r <= free_hint_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    cur_r <= cur_nxt;
    val_r <= val_nxt;
    keep_r <= keep_nxt;
    iter_r <= iter_nxt;
    acc_r <= acc_nxt;
    walking_r <= walking_nxt;
    out_r <= out_nxt;
  end

  logic [27:0] slot;
  assign slot = cur_r - fcte_pkg::FIRST_CLUSTER;

  always_comb begin
    logic [27:0] nc;
    state_nxt = state_r;
    clr_nxt = clr_r;
    hint_valid_nxt = hint_valid_r;
    free_hint_nxt = free_hint_r;
    next_free_nxt = next_free_r;
    out_valid_nxt = out_valid_r;
    mode_nxt = mode_r;
    cur_nxt = cur_r;
    val_nxt = val_r;
    keep_nxt = keep_r;
    iter_nxt = iter_r;
    acc_nxt = acc_r;
    walking_nxt = walking_r;
    out_nxt = out_r;
    cmd = '0;
    addr = slot[AW-1:0];
    nc = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      fcte_pkg::S_CLEAR: begin
        addr = clr_r[AW-1:0];
        cmd.wr_en = 1'b1;
        cmd.wr_data = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(MAX_CLUSTERS - 1)) begin
          state_nxt = fcte_pkg::S_IDLE;
        end
      end
      fcte_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          mode_nxt = in_data.mode;
          val_nxt = in_data.entry_value;
          keep_nxt = in_data.keep_len;
          iter_nxt = '0;
          acc_nxt = '0;
          walking_nxt = 1'b0;
          cur_nxt = in_data.cluster;
          if (in_data.mode == fcte_pkg::MODE_ALLOC) begin
            cur_nxt = (hint_valid_r && valid_c(next_free_r, used)) ?
                      next_free_r : fcte_pkg::FIRST_CLUSTER;
          end else if (in_data.mode == fcte_pkg::MODE_COUNT) begin
            cur_nxt = fcte_pkg::FIRST_CLUSTER;
          end
          state_nxt = fcte_pkg::S_RD;
        end
      end
      fcte_pkg::S_RD: begin
        // decide whether another visit is needed; issue the read
        state_nxt = fcte_pkg::S_RD_WAIT;
        case (mode_r)
          fcte_pkg::MODE_READ: begin
            if (!cur_ok) begin
              out_nxt = {fcte_pkg::ST_INVALID, 28'd0};
              state_nxt = fcte_pkg::S_DONE;
            end
          end
          fcte_pkg::MODE_WRITE: begin
            if (!cur_ok) begin
              out_nxt = {fcte_pkg::ST_INVALID, 28'd0};
            end else if (read_only_r) begin
              out_nxt = {fcte_pkg::ST_READ_ONLY, 28'd0};
            end else begin
              cmd.wr_en = 1'b1;
              cmd.wr_data = val_r;
              out_nxt = {fcte_pkg::ST_OK, 28'd0};
            end
            state_nxt = fcte_pkg::S_DONE;
          end
          fcte_pkg::MODE_ALLOC: begin
            if (iter_r >= used) begin
              out_nxt = {fcte_pkg::ST_NO_SPACE, 28'd0};
              state_nxt = fcte_pkg::S_DONE;
            end
          end
          fcte_pkg::MODE_FREE: begin
            if (!cur_ok || iter_r > MAXC) begin
              out_nxt = {fcte_pkg::ST_OK, 28'd0};
              state_nxt = fcte_pkg::S_DONE;
            end
          end
          fcte_pkg::MODE_TRUNC: begin
            if (walking_r || keep_r == 13'd0) begin
              if (!cur_ok || iter_r > MAXC) begin
                out_nxt = {fcte_pkg::ST_OK, 28'd0};
                state_nxt = fcte_pkg::S_DONE;
              end
            end else if (!cur_ok) begin
              out_nxt = {fcte_pkg::ST_INVALID, 28'd0};
              state_nxt = fcte_pkg::S_DONE;
            end
          end
          fcte_pkg::MODE_COUNT: begin
            if (hint_valid_r) begin
              out_nxt = {fcte_pkg::ST_OK, free_hint_r};
              state_nxt = fcte_pkg::S_DONE;
            end else if (iter_r >= used) begin
              hint_valid_nxt = 1'b1;
              free_hint_nxt = acc_r;
              next_free_nxt = fcte_pkg::FIRST_CLUSTER;
              out_nxt = {fcte_pkg::ST_OK, acc_r};
              state_nxt = fcte_pkg::S_DONE;
            end
          end
          default: begin
            out_nxt = {fcte_pkg::ST_INVALID, 28'd0};
            state_nxt = fcte_pkg::S_DONE;
          end
        endcase
      end
      fcte_pkg::S_RD_WAIT: begin
        state_nxt = fcte_pkg::S_EVAL;
      end
      fcte_pkg::S_EVAL: begin
        state_nxt = fcte_pkg::S_RD;
        iter_nxt = iter_r + 1'b1;
        case (mode_r)
          fcte_pkg::MODE_READ: begin
            out_nxt = {fcte_pkg::ST_OK, rd_data};
            state_nxt = fcte_pkg::S_DONE;
          end
          fcte_pkg::MODE_ALLOC: begin
            if (rd_data == 28'd0) begin
              if (read_only_r) begin
                out_nxt = {fcte_pkg::ST_READ_ONLY, 28'd0};
              end else begin
                cmd.wr_en = 1'b1;
                cmd.wr_data = fcte_pkg::EOC_MARK;
                if (hint_valid_r && free_hint_r != 28'd0) begin
                  free_hint_nxt = free_hint_r - 1'b1;
                end
                next_free_nxt = valid_c(cur_r + 1'b1, used) ?
                                cur_r + 1'b1 : fcte_pkg::FIRST_CLUSTER;
                out_nxt = {fcte_pkg::ST_OK, cur_r};
              end
              state_nxt = fcte_pkg::S_DONE;
            end else begin
              nc = cur_r + 1'b1;
              if (nc >= used + fcte_pkg::FIRST_CLUSTER) begin
                nc = nc - used;
              end
              cur_nxt = nc;
            end
          end
          fcte_pkg::MODE_COUNT: begin
            if (rd_data == 28'd0) begin
              acc_nxt = acc_r + 1'b1;
            end
            cur_nxt = cur_r + 1'b1;
          end
          fcte_pkg::MODE_FREE, fcte_pkg::MODE_TRUNC: begin
            if (mode_r == fcte_pkg::MODE_FREE || walking_r || keep_r == 13'd0) begin
              // chain walk, freeing as it goes
              if (read_only_r) begin
                out_nxt = {fcte_pkg::ST_READ_ONLY, 28'd0};
                state_nxt = fcte_pkg::S_DONE;
              end else begin
                if (rd_data != 28'd0) begin
                  cmd.wr_en = 1'b1;
                  cmd.wr_data = '0;
                  if (hint_valid_r && free_hint_r < used) begin
                    free_hint_nxt = free_hint_r + 1'b1;
                  end
                end
                if (rd_eoc) begin
                  out_nxt = {fcte_pkg::ST_OK, 28'd0};
                  state_nxt = fcte_pkg::S_DONE;
                end
                cur_nxt = rd_data;
              end
            end else if (keep_r > 13'd1) begin
              // walking the kept part
              if (rd_eoc) begin
                out_nxt = {fcte_pkg::ST_OK, 28'd0};
                state_nxt = fcte_pkg::S_DONE;
              end else if (!rd_ok) begin
                out_nxt = {fcte_pkg::ST_INVALID, 28'd0};
                state_nxt = fcte_pkg::S_DONE;
              end
              keep_nxt = keep_r - 1'b1;
              cur_nxt = rd_data;
            end else begin
              // last kept cluster: cut here
              if (rd_eoc) begin
                out_nxt = {fcte_pkg::ST_OK, 28'd0};
                state_nxt = fcte_pkg::S_DONE;
              end else if (read_only_r) begin
                out_nxt = {fcte_pkg::ST_READ_ONLY, 28'd0};
                state_nxt = fcte_pkg::S_DONE;
              end else begin
                cmd.wr_en = 1'b1;
                cmd.wr_data = fcte_pkg::EOC_MARK;
                walking_nxt = 1'b1;
                iter_nxt = '0;
                cur_nxt = rd_data;
              end
            end
          end
          default: begin
            state_nxt = fcte_pkg::S_DONE;
          end
        endcase
      end
      fcte_pkg::S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = fcte_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fcte_pkg::S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire
